@@ rtl/core/stack_machine_executor_unit_defines.svh @@
// Assertion macros shared by the stack machine executor RTL.
`ifndef STACK_MACHINE_EXECUTOR_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_UNIT_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SME_ASSERT_ALW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define SME_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SME_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sme_pkg.sv @@
// Shared types and constants for the stack machine executor.
`timescale 1ns / 1ps
package sme_pkg;

  // Default sizes of the stack, the data memory and the program.
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int DATA_DEPTH_DEF  = 1024;
  localparam int PROG_DEPTH_DEF  = 1024;

  // Depth of the queues between the stages.
  localparam int QUEUE_DEPTH = 2;

  // Field widths of a beat.
  localparam int CMD_W   = 4;
  localparam int WORD_W  = 32;
  localparam int TGT_W   = 10;
  localparam int STAT_W  = 3;

  // Constants produced by the compare instruction.
  localparam logic signed [WORD_W-1:0] VAL_ONE       = 32'sd1;
  localparam logic signed [WORD_W-1:0] VAL_MINUS_ONE = -32'sd1;
  localparam logic signed [WORD_W-1:0] VAL_ZERO      = 32'sd0;

  // Instruction codes; anything unlisted decodes to a no-op.
  typedef enum logic [CMD_W-1:0] {
    OP_LD  = 4'd0,
    OP_ST  = 4'd1,
    OP_LDC = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_CMP = 4'd5,
    OP_JMP = 4'd6,
    OP_BR  = 4'd7,
    OP_RET = 4'd8,
    OP_NOP = 4'd15
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_HALT  = 3'd1,
    ST_OVER  = 3'd2,
    ST_UNDER = 3'd3,
    ST_ADDR  = 3'd4
  } status_t;

  // Decoded instruction handed from the front to the back.
  typedef struct packed {
    op_t                      op;
    logic signed [WORD_W-1:0] operand;
    logic [TGT_W-1:0]         target;
    logic                     addr_ok;
    logic                     tgt_ok;
  } dec_t;

  // One result beat.
  typedef struct packed {
    logic [TGT_W-1:0]         next_pc;
    status_t                  status;
    logic signed [WORD_W-1:0] value;
  } res_t;

  // Status that the back reports to the front.
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

@@ rtl/core/sme_fifo.sv @@
// Small first-in first-out queue with full and empty flags.
`timescale 1ns / 1ps
`include "stack_machine_executor_unit_defines.svh"
module sme_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = sme_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             wr_fire;
  logic             rd_fire;

  // Flags and handshake qualification.
  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign wr_fire = wr && !full;
  assign rd_fire = rd && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage for the waiting beats.
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_fire) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_fire && !rd_fire) begin
        count <= count + CNTW'(1);
      end else if (rd_fire && !wr_fire) begin
        count <= count - CNTW'(1);
      end
    end
  end

  // The fill count tracks the beats in and out.
  `SME_ASSERT_ALW(a_fifo_bound, count <= CNTW'(DEPTH), "fifo count beyond depth")
  `SME_ASSERT_NXT(a_fifo_up, wr_fire && !rd_fire, count == $past(count) + CNTW'(1), "fifo count did not rise")
  `SME_ASSERT_NXT(a_fifo_dn, rd_fire && !wr_fire, count == $past(count) - CNTW'(1), "fifo count did not fall")

endmodule

@@ rtl/core/sme_front.sv @@
// Front stage: accepts instruction beats, classifies them and queues them.
`timescale 1ns / 1ps
module sme_front #(
  parameter int DATA_DEPTH = sme_pkg::DATA_DEPTH_DEF,
  parameter int PROG_DEPTH = sme_pkg::PROG_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [sme_pkg::CMD_W-1:0]         cmd,
  input  logic signed [sme_pkg::WORD_W-1:0] operand,
  input  logic [sme_pkg::TGT_W-1:0]         target,
  input  sme_pkg::back_stat_t               back_stat,
  input  logic                              q_pop,
  output logic                              q_empty,
  output sme_pkg::dec_t                     q_item
);
  import sme_pkg::*;

  dec_t                dec;
  logic                q_full;
  logic [$bits(dec_t)-1:0] q_rdata;

  // Decode the opcode; codes outside the instruction set become no-ops.
  always_comb begin
    unique case (cmd) inside
      OP_LD, OP_ST, OP_LDC, OP_ADD, OP_SUB, OP_CMP, OP_JMP, OP_BR, OP_RET: begin
        dec.op = op_t'(cmd);
      end
      default: begin
        dec.op = OP_NOP;
      end
    endcase
    dec.operand = operand;
    dec.target  = target;
    // Data addresses must be non-negative and inside the data memory.
    dec.addr_ok = !operand[WORD_W-1] && (unsigned'(operand) < WORD_W'(DATA_DEPTH));
    // Branch targets must lie inside the program.
    dec.tgt_ok  = ({{(WORD_W-TGT_W){1'b0}}, target} < WORD_W'(PROG_DEPTH));
  end

  // No beat is taken while the back clears its data memory.
  assign full = q_full || back_stat.clearing;

  // Queue of decoded instructions between the front and the back.
  sme_fifo #(
    .WIDTH ($bits(dec_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_iq (
    .clk   (clk),
    .rst   (rst),
    .wr    (push && !full),
    .wdata (dec),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_item = dec_t'(q_rdata);

endmodule

@@ rtl/core/sme_back.sv @@
// Back stage: executes decoded instructions on the stack and data memory.
`timescale 1ns / 1ps
`include "stack_machine_executor_unit_defines.svh"
module sme_back #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int DATA_DEPTH  = sme_pkg::DATA_DEPTH_DEF,
  parameter int PROG_DEPTH  = sme_pkg::PROG_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  sme_pkg::dec_t       q_item,
  input  logic                res_full,
  output logic                res_push,
  output sme_pkg::res_t       res_item,
  output sme_pkg::back_stat_t back_stat
);
  import sme_pkg::*;

  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int PCW = $clog2(PROG_DEPTH);
  localparam int PCX = (PCW > TGT_W) ? PCW : TGT_W;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_ISSUE = 3'b010,
    S_EXEC  = 3'b100
  } bstate_t;

  // The top of stack lives in a register; the memory holds the entries below it.
  logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
  logic [WORD_W-1:0] dm_mem  [DATA_DEPTH];

  bstate_t           state;
  bstate_t           state_next;
  logic [DAW-1:0]    clr_addr;
  dec_t              cur;
  logic [WORD_W-1:0] stk_rd;
  logic [WORD_W-1:0] dm_rd;
  logic [WORD_W-1:0] top;
  logic [WORD_W-1:0] top_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [PCW-1:0]    pc;
  logic [PCW-1:0]    npc;
  logic [PCX-1:0]    npc_ext;
  logic              halted;
  logic              halted_next;
  status_t           status;
  logic              issue;
  logic              exec;
  logic              stk_push;
  logic              stk_we;
  logic              dm_st;
  logic              dm_we;
  logic [DAW-1:0]    dm_waddr;
  logic [WORD_W-1:0] dm_wdata;
  logic [SW-1:0]     rd_idx;
  logic [SW-1:0]     wr_idx;
  logic [WORD_W-1:0] alu_r;

  // Handshakes with the instruction queue and the result queue.
  assign issue     = (state == S_ISSUE) && !q_empty;
  assign exec      = (state == S_EXEC) && !res_full;
  assign q_pop     = issue;
  assign res_push  = exec;
  assign back_stat.clearing = (state == S_CLEAR);

  // The entry below the top, and the slot the old top moves into on a push.
  assign rd_idx = SW'(count - CW'(2));
  assign wr_idx = SW'(count - CW'(1));

  // Sequencer: clear the data memory after reset, then read and execute.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == DAW'(DATA_DEPTH - 1)) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (issue) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec) begin
          state_next = S_ISSUE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Arithmetic on the top (a) and the next entry (b).
  always_comb begin
    case (cur.op)
      OP_ADD: alu_r = top + stk_rd;
      OP_SUB: alu_r = top - stk_rd;
      default: begin
        if ($signed(top) > $signed(stk_rd)) begin
          alu_r = VAL_ONE;
        end else if ($signed(top) < $signed(stk_rd)) begin
          alu_r = VAL_MINUS_ONE;
        end else begin
          alu_r = VAL_ZERO;
        end
      end
    endcase
  end

  // Execute the current instruction against the machine state.
  always_comb begin
    status      = ST_OK;
    npc         = (pc == PCW'(PROG_DEPTH - 1)) ? '0 : pc + PCW'(1);
    top_next    = top;
    count_next  = count;
    halted_next = halted;
    stk_push    = 1'b0;
    dm_st       = 1'b0;
    if (halted) begin
      status = ST_HALT;
      npc    = pc;
    end else begin
      case (cur.op) inside
        OP_LD: begin
          if (count == CW'(STACK_DEPTH)) begin
            status = ST_OVER;
          end else if (!cur.addr_ok) begin
            status = ST_ADDR;
          end else begin
            stk_push   = 1'b1;
            top_next   = dm_rd;
            count_next = count + CW'(1);
          end
        end
        OP_ST: begin
          if (count == '0) begin
            status = ST_UNDER;
          end else if (!cur.addr_ok) begin
            status = ST_ADDR;
          end else begin
            dm_st      = 1'b1;
            top_next   = (count < CW'(2)) ? VAL_ZERO : stk_rd;
            count_next = count - CW'(1);
          end
        end
        OP_LDC: begin
          if (count == CW'(STACK_DEPTH)) begin
            status = ST_OVER;
          end else begin
            stk_push   = 1'b1;
            top_next   = cur.operand;
            count_next = count + CW'(1);
          end
        end
        OP_ADD, OP_SUB, OP_CMP: begin
          if (count < CW'(2)) begin
            status = ST_UNDER;
          end else begin
            top_next   = alu_r;
            count_next = count - CW'(1);
          end
        end
        OP_JMP: begin
          if (!cur.tgt_ok) begin
            status = ST_ADDR;
          end else begin
            npc = PCW'(cur.target);
          end
        end
        OP_BR: begin
          if (count == '0) begin
            status = ST_UNDER;
          end else if (top != '0) begin
            if (!cur.tgt_ok) begin
              status = ST_ADDR;
            end else begin
              npc = PCW'(cur.target);
            end
          end
        end
        OP_RET: begin
          if (count == '0) begin
            status = ST_UNDER;
          end else begin
            halted_next = 1'b1;
            status      = ST_HALT;
            npc         = pc;
          end
        end
        default: begin
        end
      endcase
      // A faulting instruction leaves the program counter where it is.
      if (status == ST_OVER || status == ST_UNDER || status == ST_ADDR) begin
        npc = pc;
      end
    end
  end

  // Result beat for the current instruction.
  assign npc_ext          = PCX'(npc);
  assign res_item.next_pc = npc_ext[TGT_W-1:0];
  assign res_item.status  = status;
  assign res_item.value   = top_next;

  // Memory write controls.
  assign stk_we   = exec && stk_push && (count != '0);
  assign dm_we    = (state == S_CLEAR) || (exec && dm_st);
  assign dm_waddr = (state == S_CLEAR) ? clr_addr : cur.operand[DAW-1:0];
  assign dm_wdata = (state == S_CLEAR) ? VAL_ZERO : top;

  // Operand stack memory: read at issue, written at execute.
  always_ff @(posedge clk) begin
    if (issue) begin
      stk_rd <= stk_mem[rd_idx];
    end
    if (stk_we) begin
      stk_mem[wr_idx] <= top;
    end
  end

  // Data memory: read at issue, written at execute or by the clearing pass.
  always_ff @(posedge clk) begin
    if (issue) begin
      dm_rd <= dm_mem[q_item.operand[DAW-1:0]];
    end
    if (dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
  end

  // Instruction held from issue through execute.
  always_ff @(posedge clk) begin
    if (issue) begin
      cur <= q_item;
    end
  end

  // Machine state and sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      top      <= '0;
      count    <= '0;
      pc       <= '0;
      halted   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + DAW'(1);
      end
      if (exec) begin
        top    <= top_next;
        count  <= count_next;
        pc     <= npc;
        halted <= halted_next;
      end
    end
  end

  // Sequencing and machine state invariants.
  `SME_ASSERT_NXT(a_issue_exec, issue, state == S_EXEC, "issue not followed by execute")
  `SME_ASSERT_NXT(a_halt_sticky, halted, halted, "halted flag cleared")
  `SME_ASSERT_ALW(a_count_bound, count <= CW'(STACK_DEPTH), "stack count beyond depth")
  `SME_ASSERT_IMP(a_empty_top, count == '0, top == '0, "empty stack with nonzero top")

endmodule

@@ rtl/core/stack_machine_executor_unit.sv @@
// Flow: a beat goes through the instruction queue, the issue and execute states of the back
// stage and the result queue before empty falls. The back takes a new instruction only after
// the last has executed; it reads the stack and data memories at issue and writes back at execute.
// Reset: rst is synchronous and active high; it empties the stack and the queues and
// then clears every data memory address in turn, during which full stays high.
`timescale 1ns / 1ps
module stack_machine_executor_unit #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int DATA_DEPTH  = sme_pkg::DATA_DEPTH_DEF,
  parameter int PROG_DEPTH  = sme_pkg::PROG_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [sme_pkg::CMD_W-1:0]          cmd,
  input  logic signed [sme_pkg::WORD_W-1:0]  operand,
  input  logic [sme_pkg::TGT_W-1:0]          target,
  output logic                               empty,
  input  logic                               pop,
  output logic [sme_pkg::TGT_W-1:0]          next_pc,
  output logic [sme_pkg::STAT_W-1:0]         status,
  output logic signed [sme_pkg::WORD_W-1:0]  value
);
  import sme_pkg::*;

  logic                    q_pop;
  logic                    q_empty;
  dec_t                    q_item;
  back_stat_t              back_stat;
  logic                    res_full;
  logic                    res_push;
  res_t                    res_item;
  logic [$bits(res_t)-1:0] out_raw;
  res_t                    out_item;

  // Front: takes instruction beats and queues them decoded.
  sme_front #(
    .DATA_DEPTH (DATA_DEPTH),
    .PROG_DEPTH (PROG_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .operand   (operand),
    .target    (target),
    .back_stat (back_stat),
    .q_pop     (q_pop),
    .q_empty   (q_empty),
    .q_item    (q_item)
  );

  // Back: executes instructions against the stack and data memory.
  sme_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_DEPTH  (DATA_DEPTH),
    .PROG_DEPTH  (PROG_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item),
    .back_stat (back_stat)
  );

  // Result queue so the back keeps going while a result waits.
  sme_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_rq (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_item),
    .full  (res_full),
    .rd    (pop),
    .rdata (out_raw),
    .empty (empty)
  );

  // Unpack the oldest result beat onto the ports.
  assign out_item = res_t'(out_raw);
  assign next_pc  = out_item.next_pc;
  assign status   = out_item.status;
  assign value    = out_item.value;

endmodule
